### rtl/ba_pkg.sv
`timescale 1ns / 1ps
package ba_pkg;

  localparam int ORDER_CAP    = 20;
  localparam int RECORD_SLOTS = 64;
  localparam int HANDLE_WIDTH = 16;
  localparam int LIST_DEPTH   = RECORD_SLOTS + 1;
  localparam int LIST_WORDS   = (ORDER_CAP + 1) * LIST_DEPTH;
  localparam int LIST_AW      = $clog2(LIST_WORDS);
  localparam int SLOT_W       = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;
  localparam int SCAN_W       = $clog2(RECORD_SLOTS + 1);
  localparam int LEN_W        = $clog2(LIST_DEPTH + 1);
  localparam int ORD_W        = 5;
  localparam int ADDR_W       = 20;
  localparam int SIZE_W       = 24;
  localparam int BYTES_W      = 21;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOBLOCK = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef struct packed {
    logic [HANDLE_WIDTH-1:0] handle;
    logic [ADDR_W-1:0]       addr;
    logic [ORD_W-1:0]        ord;
    logic [SIZE_W-1:0]       size;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  function automatic logic [ORD_W-1:0] ceil_log2(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] v;
    logic [ORD_W-1:0]  r;
    v = size - SIZE_W'(1);
    r = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (v[i]) r = ORD_W'(i + 1);
    end
    return r;
  endfunction

  function automatic logic [LIST_AW-1:0] list_addr(input logic [ORD_W-1:0] ord,
                                                   input logic [LEN_W-1:0] idx);
    return LIST_AW'(ord) * LIST_AW'(LIST_DEPTH) + LIST_AW'(idx);
  endfunction

endpackage

### rtl/ba_ram.sv
`timescale 1ns / 1ps
module ba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### rtl/buddy_allocator_core.sv
`timescale 1ns / 1ps
// Buddy allocator over a pool of 2^total_order bytes (capped at order 20). One word in,
// one word out. Free lists live in a single-port-read RAM of 21 x 65 addresses; records
// in a 64-entry RAM. An allocate checks orders upward for a non-empty free list, scans for
// the first free record slot, takes the list head by shifting the rest of the list down,
// then splits down to the requested order; a zero size skips these steps. A free scans the
// records for a matching handle, then at each order searches the list for the buddy,
// removes it and merges, and pushes the block on the order where merging stops (with no
// search at the top order); an unknown id answers after the whole record scan. A new word
// is taken once a result is presented, before it is accepted; the next result waits for that.
// Reset and every total_order write pass through S_INIT before a word is taken.
module buddy_allocator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [23:0] request_size,
  input  logic [15:0] handle_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] handle_out,
  output logic [19:0] block_address,
  output logic [4:0]  block_order,
  output logic [20:0] used_total,
  output logic [20:0] waste_total,
  output logic [31:0] requests_seen,
  output logic [31:0] failures_seen
);

  typedef enum logic [14:0] {
    S_INIT    = 15'b000000000000001,
    S_IDLE    = 15'b000000000000010,
    S_A_ORD   = 15'b000000000000100,
    S_A_SCAN  = 15'b000000000001000,
    S_A_SLOT  = 15'b000000000010000,
    S_A_HEAD  = 15'b000000000100000,
    S_SH_RD   = 15'b000000001000000,
    S_SH_WR   = 15'b000000010000000,
    S_A_SPLIT = 15'b000000100000000,
    S_A_REC   = 15'b000001000000000,
    S_F_SCAN  = 15'b000010000000000,
    S_M_START = 15'b000100000000000,
    S_M_SCAN  = 15'b001000000000000,
    S_F_PUSH  = 15'b010000000000000,
    S_FIN     = 15'b100000000000000
  } state_t;

  state_t state;

  logic [4:0]                       total_order;
  logic [ba_pkg::ORD_W-1:0]         top;
  logic [ba_pkg::LEN_W-1:0]         len [0:ba_pkg::ORDER_CAP];
  logic [ba_pkg::RECORD_SLOTS-1:0]  valid;
  logic [ba_pkg::HANDLE_WIDTH-1:0]  next_handle;
  logic [ba_pkg::BYTES_W-1:0]       used_bytes;
  logic [ba_pkg::BYTES_W-1:0]       wasted_bytes;
  logic [31:0]                      request_count;
  logic [31:0]                      failure_count;

  logic                             op;
  logic [ba_pkg::SIZE_W-1:0]        size;
  logic [ba_pkg::HANDLE_WIDTH-1:0]  hin;
  logic [ba_pkg::ORD_W-1:0]         ord;
  logic [ba_pkg::ORD_W-1:0]         cur;
  logic [ba_pkg::SLOT_W-1:0]        slot;
  logic [ba_pkg::ADDR_W-1:0]        addr;
  logic [ba_pkg::LEN_W-1:0]         p;
  logic [ba_pkg::SCAN_W-1:0]        scan;
  logic [ba_pkg::LEN_W-1:0]         lscan;
  logic [ba_pkg::SLOT_W-1:0]        cmp_slot;
  logic [ba_pkg::LEN_W-1:0]         cmp_p;
  logic                             cmp_live;
  ba_pkg::status_t                  stat;
  logic [ba_pkg::HANDLE_WIDTH-1:0]  hout;
  logic [ba_pkg::ADDR_W-1:0]        baddr;
  logic [ba_pkg::ORD_W-1:0]         bord;

  logic                             l_we;
  logic [ba_pkg::LIST_AW-1:0]       l_waddr;
  logic [ba_pkg::ADDR_W-1:0]        l_wdata;
  logic [ba_pkg::LIST_AW-1:0]       l_raddr;
  logic [ba_pkg::ADDR_W-1:0]        l_rdata;
  logic                             r_we;
  logic [ba_pkg::REC_W-1:0]         r_wdata;
  logic [ba_pkg::SLOT_W-1:0]        r_raddr;
  logic [ba_pkg::REC_W-1:0]         r_rdata;
  ba_pkg::rec_t                     rec_rd;
  ba_pkg::rec_t                     rec_wr;

  logic [ba_pkg::ORD_W-1:0]         cur_dn;
  logic [ba_pkg::ADDR_W-1:0]        buddy;
  logic [ba_pkg::BYTES_W-1:0]       blk_alloc;
  logic [ba_pkg::BYTES_W-1:0]       blk_free;

  assign top       = (total_order > 5'(ba_pkg::ORDER_CAP)) ? 5'(ba_pkg::ORDER_CAP) : total_order;
  assign cur_dn    = cur - 5'd1;
  assign buddy     = addr ^ (ba_pkg::ADDR_W'(1) << cur);
  assign rec_rd    = ba_pkg::rec_t'(r_rdata);
  assign blk_alloc = ba_pkg::BYTES_W'(1) << ord;
  assign blk_free  = ba_pkg::BYTES_W'(1) << rec_rd.ord;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    rec_wr.handle = next_handle;
    rec_wr.addr   = addr;
    rec_wr.ord    = ord;
    rec_wr.size   = size;
  end

  ba_ram #(.WIDTH(ba_pkg::ADDR_W), .DEPTH(ba_pkg::LIST_WORDS)) u_list (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  ba_ram #(.WIDTH(ba_pkg::REC_W), .DEPTH(ba_pkg::RECORD_SLOTS)) u_rec (
    .clk   (clk),
    .we    (r_we),
    .waddr (slot),
    .wdata (r_wdata),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  always_comb begin
    l_we    = 1'b0;
    l_waddr = ba_pkg::list_addr(cur, p);
    l_wdata = l_rdata;
    l_raddr = ba_pkg::list_addr(cur, ba_pkg::LEN_W'(p + 1'b1));
    r_we    = 1'b0;
    r_wdata = rec_wr;
    r_raddr = scan[ba_pkg::SLOT_W-1:0];
    unique case (state)
      S_INIT: begin
        l_we    = 1'b1;
        l_waddr = ba_pkg::list_addr(top, '0);
        l_wdata = '0;
      end
      S_A_SLOT: begin
        l_raddr = ba_pkg::list_addr(cur, '0);
      end
      S_SH_WR: begin
        l_we = 1'b1;
      end
      S_A_SPLIT: begin
        l_we    = (cur > ord) && (len[cur_dn] < ba_pkg::LEN_W'(ba_pkg::LIST_DEPTH));
        l_waddr = ba_pkg::list_addr(cur_dn, len[cur_dn]);
        l_wdata = addr + (ba_pkg::ADDR_W'(1) << cur_dn);
      end
      S_A_REC: begin
        r_we = 1'b1;
      end
      S_M_SCAN: begin
        l_raddr = ba_pkg::list_addr(cur, lscan);
      end
      S_F_PUSH: begin
        l_we    = len[cur] < ba_pkg::LEN_W'(ba_pkg::LIST_DEPTH);
        l_waddr = ba_pkg::list_addr(cur, len[cur]);
        l_wdata = addr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      total_order   <= 5'(ba_pkg::ORDER_CAP);
      valid         <= '0;
      next_handle   <= ba_pkg::HANDLE_WIDTH'(1);
      used_bytes    <= '0;
      wasted_bytes  <= '0;
      request_count <= '0;
      failure_count <= '0;
      out_valid     <= 1'b0;
    end else if (cfg_write) begin
      state         <= S_INIT;
      total_order   <= cfg_data;
      valid         <= '0;
      next_handle   <= ba_pkg::HANDLE_WIDTH'(1);
      used_bytes    <= '0;
      wasted_bytes  <= '0;
      request_count <= '0;
      failure_count <= '0;
    end else begin
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_INIT: begin
          for (int i = 0; i <= ba_pkg::ORDER_CAP; i++) begin
            len[i] <= (5'(i) == top) ? ba_pkg::LEN_W'(1) : '0;
          end
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op       <= operation;
            size     <= request_size;
            hin      <= handle_in;
            hout     <= '0;
            baddr    <= '0;
            bord     <= '0;
            stat     <= ba_pkg::ST_OK;
            scan     <= '0;
            cmp_live <= 1'b0;
            if (!operation) begin
              request_count <= request_count + 32'd1;
              if (request_size == '0) begin
                stat  <= ba_pkg::ST_ZERO;
                state <= S_FIN;
              end else begin
                state <= S_A_ORD;
              end
            end else begin
              state <= S_F_SCAN;
            end
          end
        end
        S_A_ORD: begin
          ord   <= ba_pkg::ceil_log2(size);
          cur   <= ba_pkg::ceil_log2(size);
          state <= S_A_SCAN;
        end
        S_A_SCAN: begin
          if (cur > top) begin
            failure_count <= failure_count + 32'd1;
            stat          <= ba_pkg::ST_NOBLOCK;
            state         <= S_FIN;
          end else if (len[cur] != '0) begin
            state <= S_A_SLOT;
          end else begin
            cur <= cur + 5'd1;
          end
        end
        S_A_SLOT: begin
          if (scan == ba_pkg::SCAN_W'(ba_pkg::RECORD_SLOTS) || next_handle == '0) begin
            failure_count <= failure_count + 32'd1;
            stat          <= ba_pkg::ST_FULL;
            state         <= S_FIN;
          end else if (!valid[scan[ba_pkg::SLOT_W-1:0]]) begin
            slot  <= scan[ba_pkg::SLOT_W-1:0];
            state <= S_A_HEAD;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_A_HEAD: begin
          addr  <= l_rdata;
          p     <= '0;
          state <= S_SH_RD;
        end
        S_SH_RD: begin
          if (ba_pkg::LEN_W'(p + 1'b1) < len[cur]) begin
            state <= S_SH_WR;
          end else begin
            len[cur] <= len[cur] - 1'b1;
            if (!op) begin
              state <= S_A_SPLIT;
            end else begin
              cur   <= cur + 5'd1;
              state <= S_M_START;
            end
          end
        end
        S_SH_WR: begin
          p     <= p + 1'b1;
          state <= S_SH_RD;
        end
        S_A_SPLIT: begin
          if (cur > ord) begin
            if (len[cur_dn] < ba_pkg::LEN_W'(ba_pkg::LIST_DEPTH)) begin
              len[cur_dn] <= len[cur_dn] + 1'b1;
            end
            cur <= cur_dn;
          end else begin
            state <= S_A_REC;
          end
        end
        S_A_REC: begin
          valid[slot]  <= 1'b1;
          hout         <= next_handle;
          next_handle  <= next_handle + 1'b1;
          used_bytes   <= used_bytes + blk_alloc;
          wasted_bytes <= wasted_bytes + (blk_alloc - ba_pkg::BYTES_W'(size));
          baddr        <= addr;
          bord         <= ord;
          state        <= S_FIN;
        end
        S_F_SCAN: begin
          if (cmp_live && valid[cmp_slot] && rec_rd.handle == hin) begin
            slot            <= cmp_slot;
            valid[cmp_slot] <= 1'b0;
            addr            <= rec_rd.addr;
            cur             <= rec_rd.ord;
            used_bytes      <= used_bytes - blk_free;
            wasted_bytes    <= wasted_bytes - (blk_free - ba_pkg::BYTES_W'(rec_rd.size));
            state           <= S_M_START;
          end else if (scan == ba_pkg::SCAN_W'(ba_pkg::RECORD_SLOTS)) begin
            stat  <= ba_pkg::ST_UNKNOWN;
            state <= S_FIN;
          end else begin
            cmp_slot <= scan[ba_pkg::SLOT_W-1:0];
            cmp_live <= 1'b1;
            scan     <= scan + 1'b1;
          end
        end
        S_M_START: begin
          lscan    <= '0;
          cmp_live <= 1'b0;
          state    <= (cur < top) ? S_M_SCAN : S_F_PUSH;
        end
        S_M_SCAN: begin
          if (cmp_live && l_rdata == buddy) begin
            p <= cmp_p;
            if (buddy < addr) addr <= buddy;
            state <= S_SH_RD;
          end else if (lscan == len[cur]) begin
            state <= S_F_PUSH;
          end else begin
            cmp_p    <= lscan;
            cmp_live <= 1'b1;
            lscan    <= lscan + 1'b1;
          end
        end
        S_F_PUSH: begin
          if (len[cur] < ba_pkg::LEN_W'(ba_pkg::LIST_DEPTH)) begin
            len[cur] <= len[cur] + 1'b1;
          end
          baddr <= addr;
          bord  <= cur;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            status        <= stat;
            handle_out    <= hout;
            block_address <= baddr;
            block_order   <= bord;
            used_total    <= used_bytes;
            waste_total   <= wasted_bytes;
            requests_seen <= request_count;
            failures_seen <= failure_count;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
